>>> sv/dns_a_record_extractor_assert.svh
// Assertion macros used by the DNS A-record extractor checker
`ifndef DNS_A_RECORD_EXTRACTOR_ASSERT_SVH
`define DNS_A_RECORD_EXTRACTOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define DAR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define DAR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/dar_pkg.sv
// Types and constants of the DNS A-record extractor
`default_nettype none

package dar_pkg;

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_QNAME  = 3'd1,
		PH_QFIXED = 3'd2,
		PH_ANAME  = 3'd3,
		PH_AFIXED = 3'd4,
		PH_RDATA  = 3'd5,
		PH_DONE   = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_SHORT   = 3'd1,
		ST_NOTRESP = 3'd2,
		ST_RCODE   = 3'd3,
		ST_NOANS   = 3'd4,
		ST_NO_A    = 3'd5
	} status_t;

	typedef struct packed {
		status_t     status;
		logic [3:0]  rcode;
		logic [31:0] address;
	} result_t;

	localparam logic [3:0]  HEADER_LEN    = 4'd12;
	localparam logic [3:0]  QFIXED_LEN    = 4'd4;
	localparam logic [3:0]  AFIXED_LEN    = 4'd10;
	localparam logic [7:0]  PTR_MARK      = 8'hC0;
	localparam logic [15:0] QR_MASK       = 16'h8000;
	localparam logic [15:0] RCODE_MASK    = 16'h000F;
	localparam logic [15:0] TYPE_A        = 16'd1;
	localparam logic [15:0] IPV4_LEN      = 16'd4;

endpackage

`default_nettype wire

>>> sv/dar_parse.sv
// Byte-wise DNS response parser state and per-packet result logic
`default_nettype none

module dar_parse (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            take,
	input  wire logic [7:0]      byte_in,
	input  wire logic            last_in,
	output dar_pkg::result_t     res
);

	logic [3:0]       hpos_q, hpos_d;
	logic [15:0]      flags_q, flags_d;
	logic [15:0]      qleft_q, qleft_d;
	logic [15:0]      aleft_q, aleft_d;
	dar_pkg::phase_t  phase_q, phase_d;
	logic [7:0]       lbl_q, lbl_d;
	logic [3:0]       ffi_q, ffi_d;
	logic [15:0]      rtype_q, rtype_d;
	logic [15:0]      rlen_q, rlen_d;
	logic [15:0]      rdleft_q, rdleft_d;
	logic [31:0]      acc_q, acc_d;
	dar_pkg::status_t dec_q, dec_d;

	logic             name_end;
	logic [3:0]       ffi_inc;
	logic [15:0]      aleft_dec;
	logic [15:0]      qleft_dec;
	logic [15:0]      rdleft_dec;

	// Step one byte through the phases
	always_comb begin
		hpos_d   = hpos_q;
		flags_d  = flags_q;
		qleft_d  = qleft_q;
		aleft_d  = aleft_q;
		phase_d  = phase_q;
		lbl_d    = lbl_q;
		ffi_d    = ffi_q;
		rtype_d  = rtype_q;
		rlen_d   = rlen_q;
		rdleft_d = rdleft_q;
		acc_d    = acc_q;
		dec_d    = dec_q;
		name_end = 1'b0;
		ffi_inc  = ffi_q + 4'd1;
		aleft_dec  = aleft_q - 16'd1;
		qleft_dec  = qleft_q - 16'd1;
		rdleft_dec = rdleft_q - 16'd1;

		// name walker, shared by question and answer names
		if (ffi_q != 4'd0) begin
			name_end = 1'b1;
		end else if (lbl_q != 8'd0) begin
			name_end = 1'b0;
		end else if (byte_in == 8'd0) begin
			name_end = 1'b1;
		end

		unique case (phase_q)
			dar_pkg::PH_HEADER: begin
				case (hpos_q)
					4'd2: flags_d = {byte_in, 8'd0};
					4'd3: flags_d = flags_q | {8'd0, byte_in};
					4'd4: qleft_d = {byte_in, 8'd0};
					4'd5: qleft_d = qleft_q | {8'd0, byte_in};
					4'd6: aleft_d = {byte_in, 8'd0};
					4'd7: aleft_d = aleft_q | {8'd0, byte_in};
					default: ;
				endcase
				hpos_d = hpos_q + 4'd1;
				if (hpos_d == dar_pkg::HEADER_LEN) begin
					if ((flags_d & dar_pkg::QR_MASK) == 16'd0) begin
						dec_d   = dar_pkg::ST_NOTRESP;
						phase_d = dar_pkg::PH_DONE;
					end else if ((flags_d & dar_pkg::RCODE_MASK) != 16'd0) begin
						dec_d   = dar_pkg::ST_RCODE;
						phase_d = dar_pkg::PH_DONE;
					end else if (aleft_d == 16'd0) begin
						dec_d   = dar_pkg::ST_NOANS;
						phase_d = dar_pkg::PH_DONE;
					end else begin
						phase_d = (qleft_d != 16'd0) ? dar_pkg::PH_QNAME
							: dar_pkg::PH_ANAME;
					end
				end
			end
			dar_pkg::PH_QNAME, dar_pkg::PH_ANAME: begin
				if (ffi_q != 4'd0) begin
					ffi_d = 4'd0;
				end else if (lbl_q != 8'd0) begin
					lbl_d = lbl_q - 8'd1;
				end else if (byte_in >= dar_pkg::PTR_MARK) begin
					ffi_d = 4'd1;
				end else if (byte_in != 8'd0) begin
					lbl_d = byte_in;
				end
				if (name_end) begin
					ffi_d   = 4'd0;
					phase_d = (phase_q == dar_pkg::PH_QNAME) ? dar_pkg::PH_QFIXED
						: dar_pkg::PH_AFIXED;
				end
			end
			dar_pkg::PH_QFIXED: begin
				ffi_d = ffi_inc;
				if (ffi_inc >= dar_pkg::QFIXED_LEN) begin
					ffi_d   = 4'd0;
					qleft_d = qleft_dec;
					phase_d = (qleft_dec != 16'd0) ? dar_pkg::PH_QNAME
						: dar_pkg::PH_ANAME;
				end
			end
			dar_pkg::PH_AFIXED: begin
				case (ffi_q)
					4'd0: rtype_d = {byte_in, 8'd0};
					4'd1: rtype_d = rtype_q | {8'd0, byte_in};
					4'd8: rlen_d  = {byte_in, 8'd0};
					4'd9: rlen_d  = rlen_q | {8'd0, byte_in};
					default: ;
				endcase
				ffi_d = ffi_inc;
				if (ffi_inc >= dar_pkg::AFIXED_LEN) begin
					ffi_d    = 4'd0;
					acc_d    = 32'd0;
					rdleft_d = rlen_d;
					if (rlen_d == 16'd0) begin
						aleft_d = aleft_dec;
						if (aleft_dec == 16'd0) begin
							dec_d   = dar_pkg::ST_NO_A;
							phase_d = dar_pkg::PH_DONE;
						end else begin
							phase_d = dar_pkg::PH_ANAME;
						end
					end else begin
						phase_d = dar_pkg::PH_RDATA;
					end
				end
			end
			dar_pkg::PH_RDATA: begin
				acc_d    = {acc_q[23:0], byte_in};
				rdleft_d = rdleft_dec;
				if (rdleft_dec == 16'd0) begin
					if (rtype_q == dar_pkg::TYPE_A && rlen_q == dar_pkg::IPV4_LEN) begin
						dec_d   = dar_pkg::ST_OK;
						phase_d = dar_pkg::PH_DONE;
					end else begin
						aleft_d = aleft_dec;
						if (aleft_dec == 16'd0) begin
							dec_d   = dar_pkg::ST_NO_A;
							phase_d = dar_pkg::PH_DONE;
						end else begin
							phase_d = dar_pkg::PH_ANAME;
						end
					end
				end
			end
			dar_pkg::PH_DONE: ;
			default: ;
		endcase

		// result as seen after this byte
		if (phase_d == dar_pkg::PH_HEADER) begin
			res.status = dar_pkg::ST_SHORT;
			res.rcode  = 4'd0;
		end else begin
			res.status = (phase_d == dar_pkg::PH_DONE) ? dec_d : dar_pkg::ST_NO_A;
			res.rcode  = flags_d[3:0];
		end
		res.address = (res.status == dar_pkg::ST_OK) ? acc_d : 32'd0;
	end

	// Advance on each taken byte; return to the idle state after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hpos_q   <= '0;
			flags_q  <= '0;
			qleft_q  <= '0;
			aleft_q  <= '0;
			phase_q  <= dar_pkg::PH_HEADER;
			lbl_q    <= '0;
			ffi_q    <= '0;
			rtype_q  <= '0;
			rlen_q   <= '0;
			rdleft_q <= '0;
			acc_q    <= '0;
			dec_q    <= dar_pkg::ST_NO_A;
		end else if (take) begin
			if (last_in) begin
				hpos_q   <= '0;
				flags_q  <= '0;
				qleft_q  <= '0;
				aleft_q  <= '0;
				phase_q  <= dar_pkg::PH_HEADER;
				lbl_q    <= '0;
				ffi_q    <= '0;
				rtype_q  <= '0;
				rlen_q   <= '0;
				rdleft_q <= '0;
				acc_q    <= '0;
				dec_q    <= dar_pkg::ST_NO_A;
			end else begin
				hpos_q   <= hpos_d;
				flags_q  <= flags_d;
				qleft_q  <= qleft_d;
				aleft_q  <= aleft_d;
				phase_q  <= phase_d;
				lbl_q    <= lbl_d;
				ffi_q    <= ffi_d;
				rtype_q  <= rtype_d;
				rlen_q   <= rlen_d;
				rdleft_q <= rdleft_d;
				acc_q    <= acc_d;
				dec_q    <= dec_d;
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/dns_a_record_extractor.sv
// Top level of the DNS A-record extractor: input word register, parser, result register
`default_nettype none

//  channel | signals                              | direction | word
//  --------+--------------------------------------+-----------+---------------------------
//  in      | in_valid, in_stall, data_byte,       | into      | one packet byte, last mark
//          | last_byte                            |           |
//  out     | out_valid, out_stall, status,        | out of    | one result per packet
//          | response_code, address               |           |
//
//  One word is taken per cycle while in_stall is low. A byte is held in the input
//  register until the parser takes it and updates its state; on a last byte the
//  result register loads at that same edge and offers the word on the output.
//  Reset (arst_n low) empties both registers and puts the parser at the header.
//  out_stall holds the result register; in_stall rises only when a last byte
//  sits in the input register while the result register is full and stalled.

module dns_a_record_extractor (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       status,
	output logic [3:0]       response_code,
	output logic [31:0]      address
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              last_s1;
	logic              out_free;
	logic              go_s1;
	logic              load_s1;
	dar_pkg::result_t  res;
	dar_pkg::result_t  res_q;
	logic              out_valid_q;

	// the result slot can take a word if empty or being drained this cycle
	assign out_free = !out_valid_q || !out_stall;
	// a byte with no result never waits; a last byte waits for the slot
	assign go_s1    = valid_s1 && (!last_s1 || out_free);
	assign load_s1  = !valid_s1 || go_s1;
	assign in_stall = !load_s1;

	// input word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	dar_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (go_s1),
		.byte_in (byte_s1),
		.last_in (last_s1),
		.res     (res)
	);

	// result register: load on a last byte, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && last_s1) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = res_q.status;
	assign response_code = res_q.rcode;
	assign address       = res_q.address;

endmodule

`default_nettype wire

>>> sv/dar_checker.sv
// Port-level checks of the DNS A-record extractor and their binding
`default_nettype none

`include "dns_a_record_extractor_assert.svh"

module dar_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [2:0]  status,
	input wire logic [3:0]  response_code,
	input wire logic [31:0] address
);

	`DAR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(response_code) && $stable(address), "stalled result changed")
	`DAR_ASSERT_NOW(a_addr_zero, out_valid && status != dar_pkg::ST_OK, address == 32'd0, "address set without an A record")
	`DAR_ASSERT_NOW(a_short_rcode, out_valid && status == dar_pkg::ST_SHORT, response_code == 4'd0, "short packet carries an rcode")
	`DAR_ASSERT_NOW(a_ok_rcode, out_valid && status == dar_pkg::ST_OK, response_code == 4'd0, "ok result with nonzero rcode")

endmodule

bind dns_a_record_extractor dar_checker u_dar_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.status        (status),
	.response_code (response_code),
	.address       (address)
);

`default_nettype wire
